// File: hdl/tpo_pkg.sv
// Shared types, register map and reset values for the time-proportional output block.
// No dependencies; imported by every other module of the block.
`timescale 1ns / 1ps
package tpo_pkg;

  localparam int unsigned DutyFracBitsDef = 12;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned SecW     = 17;
  localparam int unsigned TimeW    = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PERIOD      = 3'd0,
    REG_MIN_ON      = 3'd1,
    REG_MIN_OFF     = 3'd2,
    REG_NIGHT_SRC   = 3'd3,
    REG_NIGHT_START = 3'd4,
    REG_NIGHT_END   = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    NIGHT_NONE   = 2'd0,
    NIGHT_SENSOR = 2'd1,
    NIGHT_WINDOW = 2'd2
  } night_src_e;

  localparam logic [TimeW-1:0] PeriodRst = 32'd600000;

  typedef struct packed {
    logic [TimeW-1:0] period_ms;
    logic [TimeW-1:0] min_on_ms;
    logic [TimeW-1:0] min_off_ms;
    logic [1:0]       night_source;
    logic [SecW-1:0]  night_start_sec;
    logic [SecW-1:0]  night_end_sec;
  } cfg_t;

  // word handed from the on-time stage to the drive stage
  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic [TimeW-1:0] on_time;
    logic             duty_nz;
    logic             night;
  } stage_t;

endpackage

// File: hdl/tpo_cfg_regs.sv
// APB register file for the time-proportional output block.
// Depends on tpo_pkg for the register map and the cfg_t struct.
`timescale 1ns / 1ps
module tpo_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tpo_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output tpo_pkg::cfg_t                cfg_o
);
  import tpo_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[CfgAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_PERIOD:      cfg_d.period_ms       = pwdata;
        REG_MIN_ON:      cfg_d.min_on_ms       = pwdata;
        REG_MIN_OFF:     cfg_d.min_off_ms      = pwdata;
        REG_NIGHT_SRC:   cfg_d.night_source    = pwdata[1:0];
        REG_NIGHT_START: cfg_d.night_start_sec = pwdata[SecW-1:0];
        REG_NIGHT_END:   cfg_d.night_end_sec   = pwdata[SecW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PERIOD:      prdata = cfg_q.period_ms;
      REG_MIN_ON:      prdata = cfg_q.min_on_ms;
      REG_MIN_OFF:     prdata = cfg_q.min_off_ms;
      REG_NIGHT_SRC:   prdata = {30'd0, cfg_q.night_source};
      REG_NIGHT_START: prdata = {{(32-SecW){1'b0}}, cfg_q.night_start_sec};
      REG_NIGHT_END:   prdata = {{(32-SecW){1'b0}}, cfg_q.night_end_sec};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_ms       <= PeriodRst;
      cfg_q.min_on_ms       <= '0;
      cfg_q.min_off_ms      <= '0;
      cfg_q.night_source    <= NIGHT_NONE;
      cfg_q.night_start_sec <= '0;
      cfg_q.night_end_sec   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/tpo_ontime.sv
// Input register and on-time stage: duty clamp, duty x period product, min-time
// trimming of the on-time and the night-off decision. Depends on tpo_pkg.
`timescale 1ns / 1ps
module tpo_ontime #(
  parameter int unsigned DUTY_FRAC_BITS = tpo_pkg::DutyFracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tpo_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tpo_pkg::TimeW-1:0]    now_ms_i,
  input  logic [DUTY_FRAC_BITS:0]      duty_i,
  input  logic                         night_sensor_i,
  input  logic [tpo_pkg::SecW-1:0]     day_seconds_i,
  input  logic                         clock_valid_i,
  output logic                         st_valid_o,
  output tpo_pkg::stage_t              st_o,
  input  logic                         st_ready_i
);
  import tpo_pkg::*;

  localparam int unsigned DutyW = DUTY_FRAC_BITS + 1;
  localparam int unsigned ProdW = DutyW + TimeW;
  localparam logic [DutyW-1:0] DutyFull = DutyW'(1) << DUTY_FRAC_BITS;

  logic                in_valid_q;
  logic [TimeW-1:0]    now_q;
  logic [DutyW-1:0]    duty_q;
  logic                sensor_q;
  logic [SecW-1:0]     secs_q;
  logic                cvalid_q;

  logic                st_valid_q;
  stage_t              st_q, st_d;

  logic                st_free, in_adv;
  logic [DutyW-1:0]    duty_c;
  logic [ProdW-1:0]    prod;
  logic [TimeW-1:0]    on_raw, on_min, on_time;
  logic                in_win, night;

  assign st_free    = !st_valid_q || st_ready_i;
  assign in_adv     = in_valid_q && st_free;
  assign in_ready_o = !in_valid_q || st_free;

  assign duty_c = (duty_q > DutyFull) ? DutyFull : duty_q;
  assign prod   = ProdW'(duty_c) * ProdW'(cfg_i.period_ms);
  assign on_raw = prod[DUTY_FRAC_BITS +: TimeW];

  always_comb begin
    on_min = on_raw;
    if (on_raw != '0 && on_raw < cfg_i.min_on_ms) on_min = '0;
    on_time = on_min;
    if (on_min != '0 && on_min < cfg_i.period_ms &&
        (cfg_i.period_ms - on_min) < cfg_i.min_off_ms) on_time = cfg_i.period_ms;
  end

  always_comb begin
    if (cfg_i.night_start_sec > cfg_i.night_end_sec) begin
      in_win = (secs_q >= cfg_i.night_start_sec) || (secs_q < cfg_i.night_end_sec);
    end else begin
      in_win = (secs_q >= cfg_i.night_start_sec) && (secs_q < cfg_i.night_end_sec);
    end
    unique case (night_src_e'(cfg_i.night_source))
      NIGHT_SENSOR: night = sensor_q;
      NIGHT_WINDOW: night = cvalid_q && in_win;
      default:      night = 1'b0;
    endcase
  end

  always_comb begin
    st_d.now_ms  = now_q;
    st_d.on_time = on_time;
    st_d.duty_nz = (duty_q != '0);
    st_d.night   = night;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      st_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (st_free)    st_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      now_q    <= now_ms_i;
      duty_q   <= duty_i;
      sensor_q <= night_sensor_i;
      secs_q   <= day_seconds_i;
      cvalid_q <= clock_valid_i;
    end
    if (in_adv) st_q <= st_d;
  end

  assign st_valid_o = st_valid_q;
  assign st_o       = st_q;

endmodule

// File: hdl/tpo_drive.sv
// Drive stage: period restart, minimum on/off hold and night-off forcing, with
// the drive state and the result register. Depends on tpo_pkg.
`timescale 1ns / 1ps
module tpo_drive (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tpo_pkg::cfg_t   cfg_i,
  input  logic            st_valid_i,
  output logic            st_ready_o,
  input  tpo_pkg::stage_t st_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            drive_on_o,
  output logic            drive_changed_o,
  output logic            night_blocked_o
);
  import tpo_pkg::*;

  logic             started_q, started_d;
  logic             level_q, level_d;
  logic [TimeW-1:0] pstart_q, pstart_d;
  logic [TimeW-1:0] lsw_q, lsw_d;
  logic             out_valid_q;
  logic             on_q, chg_q, blk_q;

  logic             fire;
  logic             lvl0, lvl1, want, may;
  logic [TimeW-1:0] ps0, ls0, in_per, since;

  assign st_ready_o = !out_valid_q || out_ready_i;
  assign fire       = st_valid_i && st_ready_o;

  always_comb begin
    ps0  = started_q ? pstart_q : st_i.now_ms;
    ls0  = started_q ? lsw_q    : st_i.now_ms;
    lvl0 = started_q ? level_q  : 1'b0;

    in_per = st_i.now_ms - ps0;
    since  = st_i.now_ms - ls0;

    pstart_d = ps0;
    lsw_d    = ls0;
    lvl1     = lvl0;
    if (!st_i.night && in_per >= cfg_i.period_ms) begin
      pstart_d = st_i.now_ms;
      in_per   = '0;
      if (lvl0 != st_i.duty_nz) begin
        lvl1  = st_i.duty_nz;
        lsw_d = st_i.now_ms;
      end
    end

    want    = (in_per < st_i.on_time) && st_i.duty_nz;
    may     = lvl1 ? (since >= cfg_i.min_on_ms) : (since >= cfg_i.min_off_ms);
    level_d = lvl1;
    if (st_i.night) begin
      level_d = 1'b0;
    end else if (want != lvl1 && may) begin
      level_d = want;
      lsw_d   = st_i.now_ms;
    end
    started_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      level_q     <= 1'b0;
      pstart_q    <= '0;
      lsw_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (st_ready_o) out_valid_q <= st_valid_i;
      if (fire) begin
        started_q <= started_d;
        level_q   <= level_d;
        pstart_q  <= pstart_d;
        lsw_q     <= lsw_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      on_q  <= level_d;
      chg_q <= level_d != lvl0;
      blk_q <= st_i.night;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_on_o      = on_q;
  assign drive_changed_o = chg_q;
  assign night_blocked_o = blk_q;

endmodule

// File: hdl/time_proportional_output.sv
// Time-proportional (slow PWM) relay/heater driver: top level with stream ports
// and APB register port. Depends on tpo_pkg, tpo_cfg_regs, tpo_ontime, tpo_drive.
//
// One poll word in, one result word out. A new poll is taken every clock cycle
// unless the output stalls; a poll passes the input register, the on-time
// register (duty x period product) and the result register. The drive stage
// sets the throughput: period start, last-switch time and drive level close a
// loop there. The first poll loads the period and switch time stamps. The user
// must write registers only while no poll is in flight; the block does not enforce it.
`timescale 1ns / 1ps
module time_proportional_output #(
  parameter int unsigned DUTY_FRAC_BITS = tpo_pkg::DutyFracBitsDef,
  localparam int unsigned InBits = tpo_pkg::TimeW + DUTY_FRAC_BITS + 1 + tpo_pkg::SecW + 2,
  localparam int unsigned InW    = ((InBits + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // now_ms[31:0], duty[DUTY_FRAC_BITS:0], night_sensor, day_seconds[16:0], clock_valid
  input  logic [InW-1:0]               s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // drive_on, drive_changed, night_blocked, zero fill
  output logic [7:0]                   m_axis_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tpo_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tpo_pkg::*;

  localparam int unsigned DutyW  = DUTY_FRAC_BITS + 1;
  localparam int unsigned DutyLo = TimeW;
  localparam int unsigned SensB  = DutyLo + DutyW;
  localparam int unsigned SecLo  = SensB + 1;
  localparam int unsigned CvB    = SecLo + SecW;

  cfg_t   cfg;
  stage_t st;
  logic   st_valid, st_ready;
  logic   drive_on, drive_changed, night_blocked;

  tpo_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tpo_ontime #(
    .DUTY_FRAC_BITS (DUTY_FRAC_BITS)
  ) u_ontime (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .now_ms_i       (s_axis_tdata[TimeW-1:0]),
    .duty_i         (s_axis_tdata[DutyLo +: DutyW]),
    .night_sensor_i (s_axis_tdata[SensB]),
    .day_seconds_i  (s_axis_tdata[SecLo +: SecW]),
    .clock_valid_i  (s_axis_tdata[CvB]),
    .st_valid_o     (st_valid),
    .st_o           (st),
    .st_ready_i     (st_ready)
  );

  tpo_drive u_drive (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .st_valid_i      (st_valid),
    .st_ready_o      (st_ready),
    .st_i            (st),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .drive_on_o      (drive_on),
    .drive_changed_o (drive_changed),
    .night_blocked_o (night_blocked)
  );

  assign m_axis_tdata = {5'd0, night_blocked, drive_changed, drive_on};

endmodule
